/* rtl/cht_pkg.sv */
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants for the capability handle table: operation codes,
// controller states, the table entry layout and the controller commands.
// ----------------------------------------------------------------------------
package cht_pkg;

   localparam int unsigned TABLE_ENTRIES_DEFAULT = 64;

   localparam logic [7:0]  KNOWN_MASK_RESET = 8'd63;
   localparam logic [15:0] GENERATION_RESET = 16'd1;

   typedef enum logic [1:0] {
      OP_CREATE = 2'd0,
      OP_REVOKE = 2'd1,
      OP_CHECK  = 2'd2
   } opcode_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [15:0] owner;
      logic [15:0] target;
      logic [15:0] operation;
      logic [31:0] resource;
      logic [7:0]  permissions;
      logic [15:0] generation;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // take the request word, start the table read
      logic execute;   // evaluate, write back, load the response word
   } cmd_type;

endpackage

/* rtl/cht_ctrl.sv */
// ----------------------------------------------------------------------------
// cht_ctrl
// Controller for the capability handle table: request and response handshake,
// and the two-step sequence of table read followed by evaluate and write-back.
// ----------------------------------------------------------------------------
module cht_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cht_pkg::cmd_type cmd
);
   import cht_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.execute  = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      accept       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            // take a new word only once the response slot is free or draining
            req_ready   = (!rsp_valid_ff || rsp_ready) && !reset;
            accept      = req_valid && req_ready;
            cmd.capture = accept;
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute  = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted word did not move to execute");

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |-> !rsp_valid_ff)
      else $error("execute would overwrite a pending response");

   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("execute did not present a response");
`endif

endmodule

/* rtl/cht_datapath.sv */
// ----------------------------------------------------------------------------
// cht_datapath
// Datapath for the capability handle table: request registers, entry memory,
// active and generation-written bits, lowest-free-slot encoder, evaluation of
// create, revoke and check, permission mask register and response registers.
// ----------------------------------------------------------------------------
module cht_datapath #(
   parameter int unsigned TABLE_ENTRIES = cht_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  cht_pkg::cmd_type cmd,
   input  logic [1:0]       req_opcode,
   input  logic [31:0]      req_handle,
   input  logic [15:0]      req_service_id,
   input  logic [15:0]      req_target_id,
   input  logic [15:0]      req_operation_id,
   input  logic [31:0]      req_resource_id,
   input  logic [7:0]       req_permission_bits,
   input  logic             csr_write,
   input  logic [7:0]       csr_known_permission_mask,
   output logic             rsp_ok,
   output logic [31:0]      rsp_new_handle
);
   import cht_pkg::*;

   localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // entry memory
   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;

   logic [TABLE_ENTRIES-1:0] active_ff, active_in;
   logic [TABLE_ENTRIES-1:0] gen_written_ff, gen_written_in;
   logic [7:0]               mask_ff;

   // request word
   opcode_type  opcode_ff;
   logic [15:0] handle_gen_ff;
   logic [15:0] service_ff;
   logic [15:0] target_ff;
   logic [15:0] operation_ff;
   logic [31:0] resource_ff;
   logic [7:0]  permission_ff;
   logic [IdxW-1:0] slot_ff;
   logic        handle_ok_ff;
   logic        free_found_ff;

   logic            rsp_ok_ff, rsp_ok_in;
   logic [31:0]     rsp_new_handle_ff, rsp_new_handle_in;

   logic            free_found;
   logic [IdxW-1:0] free_idx;
   logic [15:0]     handle_low;
   logic            handle_ok;
   logic [IdxW-1:0] handle_slot;
   logic [IdxW-1:0] rd_addr;

   logic [15:0]     gen_eff;
   logic [15:0]     gen_next;
   logic            entry_live;
   logic            create_args_ok;
   logic            wr_en;
   entry_type       wr_data;

   // lowest inactive slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   assign handle_low  = req_handle[15:0];
   assign handle_ok   = (handle_low != 16'd0) && (handle_low <= 16'(TABLE_ENTRIES));
   assign handle_slot = IdxW'(handle_low - 16'd1);
   assign rd_addr     = (opcode_type'(req_opcode) == OP_CREATE) ? free_idx : handle_slot;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         opcode_ff     <= opcode_type'(req_opcode);
         handle_gen_ff <= req_handle[31:16];
         service_ff    <= req_service_id;
         target_ff     <= req_target_id;
         operation_ff  <= req_operation_id;
         resource_ff   <= req_resource_id;
         permission_ff <= req_permission_bits;
         slot_ff       <= rd_addr;
         handle_ok_ff  <= handle_ok;
         free_found_ff <= free_found;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[slot_ff] <= wr_data;
      end
   end

   // an entry whose generation was never written reads as the reset generation
   assign gen_eff    = gen_written_ff[slot_ff] ? rd_data_ff.generation : GENERATION_RESET;
   assign gen_next   = ((gen_eff + 16'd1) == 16'd0) ? 16'd1 : (gen_eff + 16'd1);
   assign entry_live = handle_ok_ff && active_ff[slot_ff] && (gen_eff == handle_gen_ff);

   assign create_args_ok = (service_ff != 16'd0) && (target_ff != 16'd0) &&
                           (operation_ff != 16'd0) && (resource_ff != 32'd0) &&
                           (permission_ff != 8'd0) &&
                           ((permission_ff & ~mask_ff) == 8'd0);

   always_comb begin
      active_in         = active_ff;
      gen_written_in    = gen_written_ff;
      wr_en             = 1'b0;
      wr_data           = '0;
      rsp_ok_in         = 1'b0;
      rsp_new_handle_in = 32'd0;
      if (cmd.execute) begin
         unique case (opcode_ff)
            OP_CREATE: begin
               if (create_args_ok && free_found_ff) begin
                  wr_en                   = 1'b1;
                  wr_data.owner           = service_ff;
                  wr_data.target          = target_ff;
                  wr_data.operation       = operation_ff;
                  wr_data.resource        = resource_ff;
                  wr_data.permissions     = permission_ff;
                  wr_data.generation      = gen_eff;
                  active_in[slot_ff]      = 1'b1;
                  gen_written_in[slot_ff] = 1'b1;
                  rsp_ok_in               = 1'b1;
                  rsp_new_handle_in       = {gen_eff, 16'(slot_ff) + 16'd1};
               end
            end
            OP_REVOKE: begin
               if (entry_live) begin
                  // wipe the entry and advance its generation
                  wr_en                   = 1'b1;
                  wr_data.generation      = gen_next;
                  active_in[slot_ff]      = 1'b0;
                  gen_written_in[slot_ff] = 1'b1;
                  rsp_ok_in               = 1'b1;
               end
            end
            OP_CHECK: begin
               rsp_ok_in = entry_live && (service_ff != 16'd0) &&
                           (rd_data_ff.owner == service_ff) &&
                           (rd_data_ff.target == target_ff) &&
                           (rd_data_ff.operation == operation_ff) &&
                           (rd_data_ff.resource == resource_ff) &&
                           ((rd_data_ff.permissions & permission_ff) == permission_ff);
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff      <= '0;
         gen_written_ff <= '0;
         mask_ff        <= KNOWN_MASK_RESET;
      end else begin
         active_ff      <= active_in;
         gen_written_ff <= gen_written_in;
         if (csr_write) begin
            mask_ff <= csr_known_permission_mask;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ok_ff         <= rsp_ok_in;
         rsp_new_handle_ff <= rsp_new_handle_in;
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_new_handle = rsp_new_handle_ff;

`ifndef ASSERT_OFF
   a_create_claims: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && rsp_ok_in && opcode_ff == OP_CREATE)
      |=> (active_ff[$past(slot_ff)] && gen_written_ff[$past(slot_ff)]))
      else $error("created entry not marked active");

   a_revoke_frees: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute && rsp_ok_in && opcode_ff == OP_REVOKE)
      |=> (!active_ff[$past(slot_ff)] && gen_written_ff[$past(slot_ff)]))
      else $error("revoked entry still active");
`endif

endmodule

/* rtl/capability_handle_table.sv */
// ----------------------------------------------------------------------------
// capability_handle_table
// Table of capabilities addressed by generational handles: create, revoke and
// check, with a controller sequencing a datapath that holds the entry memory.
// ----------------------------------------------------------------------------
// Request channel (req_*): one word per operation, taken when req_valid and
// req_ready are high at a clock edge. Response channel (rsp_*): one word per
// request, in order, with rsp_ok and rsp_new_handle.
// csr_* writes the known permission mask; csr_ready is high outside reset.
// Write it only while no request is in flight.
// A taken request is registered with its entry memory read, then evaluated
// and written back in the execute state, which loads the response word and
// raises rsp_valid. No new request is taken while one is in execute.
// The lowest free slot comes from a priority encoder over the active bits.
// While a response waits on rsp_ready low, one more request is not taken
// until that response drains; the response word holds unchanged meanwhile.
// Reset: every entry inactive with generation 1 (per-entry active and
// generation-written bits clear at once, no sweep), mask back to 63; both
// ready outputs stay low while reset is high.
// ----------------------------------------------------------------------------
module capability_handle_table #(
   parameter int unsigned TABLE_ENTRIES = cht_pkg::TABLE_ENTRIES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_handle,
   input  logic [15:0] req_service_id,
   input  logic [15:0] req_target_id,
   input  logic [15:0] req_operation_id,
   input  logic [31:0] req_resource_id,
   input  logic [7:0]  req_permission_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_new_handle,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_known_permission_mask
);
   import cht_pkg::*;

   cmd_type cmd;

   assign csr_ready = !reset;

   cht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   cht_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock                     (clock),
      .reset                     (reset),
      .cmd                       (cmd),
      .req_opcode                (req_opcode),
      .req_handle                (req_handle),
      .req_service_id            (req_service_id),
      .req_target_id             (req_target_id),
      .req_operation_id          (req_operation_id),
      .req_resource_id           (req_resource_id),
      .req_permission_bits       (req_permission_bits),
      .csr_write                 (csr_valid && csr_ready),
      .csr_known_permission_mask (csr_known_permission_mask),
      .rsp_ok                    (rsp_ok),
      .rsp_new_handle            (rsp_new_handle)
   );

endmodule
